@@ sv/vcsr_pkg.sv @@
// Shared constants, result kind codes and the command type for the voxel column encoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package vcsr_pkg;

   localparam int COLUMN_HEIGHT = 256;

   // Run counters hold values up to the column height.
   localparam int RUN_W = $clog2(COLUMN_HEIGHT + 1);
   // Width of the count of solid run words one run needs, ceil(solid / 63).
   localparam int CHUNK_W = $clog2(COLUMN_HEIGHT / 63 + 2);

   localparam int COUNT_W = 11;
   localparam int COUNT_MAX = 2047;
   localparam int HDR_W = 9;
   localparam int HDR_MAX = 511;
   localparam int SOLID_RUN_MAX = 63;
   localparam int SKIP_RUN_MAX = 1023;
   localparam int COLOUR_W = 15;
   localparam int NEIGHBOUR_W = 26;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   localparam logic [1:0] KIND_RUN = 2'd0;
   localparam logic [1:0] KIND_TEXTURE = 2'd1;
   localparam logic [1:0] KIND_HEADER = 2'd2;

   // One classified voxel: which result words it causes and what they carry.
   typedef struct packed {
      logic                tex_valid;
      logic [COLOUR_W-1:0] colour;
      logic                flush_valid;
      logic [RUN_W-1:0]    skip;
      logic [RUN_W-1:0]    solid;
      logic                hdr_valid;
      logic [HDR_W-1:0]    run_count;
      logic [HDR_W-1:0]    texture_count;
      logic [31:0]         offset;
   } cmd_type;

endpackage

`default_nettype wire

@@ sv/voxel_column_surface_rle_unit.sv @@
// Voxel column surface run-length encoder: one voxel word a cycle in while full is low,
// result words out. A command passes the queue and the command register before output.
// Throughput: one voxel per cycle while each causes at most one word and pop keeps up;
// a voxel with more words holds the back end longer; the 4-entry queue absorbs bursts.
// Reset (synchronous, active high) clears the run and column counters, the column start
// offset, the queue and the output register.
`default_nettype none

module voxel_column_surface_rle_unit
   import vcsr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input side: a voxel word is taken when push is high and full is low.
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [15:0]            req_voxel_word,
   input  wire logic [NEIGHBOUR_W-1:0] req_neighbours_solid,
   input  wire logic                   req_last_in_column,
   // Result side: the oldest result word is shown while empty is low.
   output logic                        empty,
   input  wire logic                   pop,
   output logic [1:0]                  rsp_kind,
   output logic [15:0]                 rsp_word,
   output logic [HDR_W-1:0]            rsp_run_count,
   output logic [HDR_W-1:0]            rsp_texture_count,
   output logic [31:0]                 rsp_column_offset,
   output logic                        rsp_last_of_run
);

   // The front end sees every voxel, decides whether it is a surface voxel and keeps the
   // counters, so it takes a new word every cycle the queue is not full. Each voxel that
   // causes output is reduced to one command: an optional texture word, an optional run
   // flush and an optional column header with its counts and offset already worked out.
   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type head;
   logic    fifo_empty;
   logic    fifo_full;
   logic    fifo_pop;
   logic    rsp_valid;

   assign accept = push && !fifo_full;
   assign full = fifo_full;
   assign empty = !rsp_valid;

   vcsr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .voxel_word       (req_voxel_word),
      .neighbours_solid (req_neighbours_solid),
      .last_in_column   (req_last_in_column),
      .cmd              (cmd),
      .cmd_push         (cmd_push)
   );

   // The queue lets the front end keep taking voxels while the back end spells out a
   // long run flush or waits on a stalled consumer.
   vcsr_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (fifo_pop),
      .head     (head),
      .empty    (fifo_empty),
      .full     (fifo_full)
   );

   // The back end turns a command into output register words, one per cycle unless stalled.
   vcsr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .fifo_empty        (fifo_empty),
      .fifo_pop          (fifo_pop),
      .rsp_pop           (pop),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_word          (rsp_word),
      .rsp_run_count     (rsp_run_count),
      .rsp_texture_count (rsp_texture_count),
      .rsp_column_offset (rsp_column_offset),
      .rsp_last_of_run   (rsp_last_of_run)
   );

`ifndef SYNTHESIS
   // A column header always closes the words of its voxel.
   a_header_is_last : assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_kind == KIND_HEADER)) |-> rsp_last_of_run)
      else $error("column header without last_of_run");

   // Only a header carries counts and an offset.
   a_counts_header_only : assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_kind != KIND_HEADER)) |->
         ((rsp_run_count == '0) && (rsp_texture_count == '0) && (rsp_column_offset == '0)))
      else $error("counts on a word that is not a header");

   // A texture word is a 15-bit colour.
   a_texture_colour : assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_kind == KIND_TEXTURE)) |-> !rsp_word[15])
      else $error("texture word with bit 15 set");
`endif

endmodule

`default_nettype wire

@@ sv/vcsr_front.sv @@
// Front end: classifies each voxel, keeps the run and column counters, builds commands.
// Depends on vcsr_pkg.
`default_nettype none

module vcsr_front
   import vcsr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [15:0]            voxel_word,
   input  wire logic [NEIGHBOUR_W-1:0] neighbours_solid,
   input  wire logic                   last_in_column,
   output cmd_type                     cmd,
   output logic                        cmd_push
);

   localparam logic [RUN_W-1:0] HEIGHT = RUN_W'(COLUMN_HEIGHT);

   logic [RUN_W-1:0]   skip_ff, skip_in;
   logic [RUN_W-1:0]   solid_ff, solid_in;
   logic [5:0]         mod_ff, mod_in;
   logic [CHUNK_W-1:0] chunks_ff, chunks_in;
   logic [COUNT_W-1:0] runs_ff, runs_in;
   logic [COUNT_W-1:0] tex_ff, tex_in;
   logic [31:0]        start_ff, start_in;

   logic               kept;
   logic               solid_at_max;
   logic [RUN_W-1:0]   solid_inc;
   logic [5:0]         mod_inc;
   logic [CHUNK_W-1:0] chunks_inc;
   logic [RUN_W-1:0]   skip_inc;
   logic               flush_valid;
   logic [RUN_W-1:0]   flush_solid;
   logic [CHUNK_W-1:0] flush_chunks;
   logic               skip_split;
   logic [CHUNK_W:0]   new_runs;
   logic [COUNT_W:0]   runs_sum;
   logic [COUNT_W-1:0] runs_new;
   logic [COUNT_W-1:0] tex_new;
   logic [31:0]        next_start;

   always_comb begin
      kept = voxel_word[15] && (neighbours_solid != '1);

      // The solid run also tracks its length modulo 63 and the words it will need.
      solid_at_max = (solid_ff == HEIGHT);
      solid_inc = solid_at_max ? solid_ff : solid_ff + 1'b1;
      if (solid_at_max) begin
         mod_inc = mod_ff;
         chunks_inc = chunks_ff;
      end else begin
         mod_inc = (mod_ff == 6'(SOLID_RUN_MAX - 1)) ? 6'd0 : mod_ff + 6'd1;
         chunks_inc = (mod_ff == 6'd0) ? chunks_ff + 1'b1 : chunks_ff;
      end
      skip_inc = (skip_ff == HEIGHT) ? skip_ff : skip_ff + 1'b1;

      // A kept voxel closes its run only at the column end.
      flush_valid = kept ? last_in_column : (solid_ff != '0);
      flush_solid = kept ? solid_inc : solid_ff;
      flush_chunks = kept ? chunks_inc : chunks_ff;
      skip_split = (16'(skip_ff) > 16'(SKIP_RUN_MAX));
      new_runs = flush_valid ? ((CHUNK_W+1)'(flush_chunks) + (CHUNK_W+1)'(skip_split))
                             : '0;

      runs_sum = (COUNT_W+1)'(runs_ff) + (COUNT_W+1)'(new_runs);
      runs_new = (runs_sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                      : runs_sum[COUNT_W-1:0];
      tex_new = (kept && (tex_ff != COUNT_W'(COUNT_MAX))) ? tex_ff + 1'b1 : tex_ff;
      next_start = start_ff + 32'd2 + 32'(runs_new) + 32'(tex_new);

      cmd.tex_valid = kept;
      cmd.colour = voxel_word[COLOUR_W-1:0];
      cmd.flush_valid = flush_valid;
      cmd.skip = skip_ff;
      cmd.solid = flush_solid;
      cmd.hdr_valid = last_in_column;
      cmd.run_count = (runs_new > COUNT_W'(HDR_MAX)) ? HDR_W'(HDR_MAX)
                                                     : runs_new[HDR_W-1:0];
      cmd.texture_count = (tex_new > COUNT_W'(HDR_MAX)) ? HDR_W'(HDR_MAX)
                                                        : tex_new[HDR_W-1:0];
      cmd.offset = start_ff;
      cmd_push = accept && (kept || flush_valid || last_in_column);

      skip_in = skip_ff;
      solid_in = solid_ff;
      mod_in = mod_ff;
      chunks_in = chunks_ff;
      runs_in = runs_ff;
      tex_in = tex_ff;
      start_in = start_ff;
      if (accept) begin
         if (last_in_column) begin
            skip_in = '0;
            solid_in = '0;
            mod_in = '0;
            chunks_in = '0;
            runs_in = '0;
            tex_in = '0;
            start_in = next_start;
         end else if (kept) begin
            solid_in = solid_inc;
            mod_in = mod_inc;
            chunks_in = chunks_inc;
            tex_in = tex_new;
         end else begin
            runs_in = runs_new;
            if (flush_valid) begin
               // The flush clears the skip count, then this voxel counts as one skip.
               skip_in = RUN_W'(1);
               solid_in = '0;
               mod_in = '0;
               chunks_in = '0;
            end else begin
               skip_in = skip_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= '0;
         solid_ff <= '0;
         mod_ff <= '0;
         chunks_ff <= '0;
         runs_ff <= '0;
         tex_ff <= '0;
         start_ff <= '0;
      end else begin
         skip_ff <= skip_in;
         solid_ff <= solid_in;
         mod_ff <= mod_in;
         chunks_ff <= chunks_in;
         runs_ff <= runs_in;
         tex_ff <= tex_in;
         start_ff <= start_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/vcsr_fifo.sv @@
// Short command queue between the front end and the back end.
// Depends on vcsr_pkg.
`default_nettype none

module vcsr_fifo
   import vcsr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         empty,
   output logic         full
);

   cmd_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      empty = (count_ff == '0);
      full = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
      do_push = push && !full;
      do_pop = pop && !empty;
      head = mem_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/vcsr_back.sv @@
// Back end: expands one command into its result words and holds the output register.
// Depends on vcsr_pkg.
`default_nettype none

module vcsr_back
   import vcsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     head,
   input  wire logic        fifo_empty,
   output logic             fifo_pop,
   input  wire logic        rsp_pop,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [15:0]      rsp_word,
   output logic [HDR_W-1:0] rsp_run_count,
   output logic [HDR_W-1:0] rsp_texture_count,
   output logic [31:0]      rsp_column_offset,
   output logic             rsp_last_of_run
);

   cmd_type          cur_ff, cur_in, after;
   logic             valid_ff, valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [15:0]      word_ff, word_in;
   logic [HDR_W-1:0] rc_ff, rc_in;
   logic [HDR_W-1:0] tc_ff, tc_in;
   logic [31:0]      off_ff, off_in;
   logic             last_ff, last_in;

   logic             busy;
   logic             step;
   logic             load;
   logic [15:0]      skip_x;
   logic [15:0]      solid_x;

   always_comb begin
      busy = cur_ff.tex_valid || cur_ff.flush_valid || cur_ff.hdr_valid;
      step = busy && (!valid_ff || rsp_pop);
      skip_x = 16'(cur_ff.skip);
      solid_x = 16'(cur_ff.solid);

      after = cur_ff;
      kind_in = KIND_RUN;
      word_in = '0;
      rc_in = '0;
      tc_in = '0;
      off_in = '0;
      // Texture first, then the run words, then the header.
      if (cur_ff.tex_valid) begin
         kind_in = KIND_TEXTURE;
         word_in = {1'b0, cur_ff.colour};
         after.tex_valid = 1'b0;
      end else if (cur_ff.flush_valid) begin
         if (skip_x > 16'(SKIP_RUN_MAX)) begin
            word_in = 16'(SKIP_RUN_MAX);
            after.skip = cur_ff.skip - RUN_W'(SKIP_RUN_MAX);
         end else if (solid_x > 16'(SOLID_RUN_MAX)) begin
            word_in = {6'(SOLID_RUN_MAX), skip_x[9:0]};
            after.solid = cur_ff.solid - RUN_W'(SOLID_RUN_MAX);
            after.skip = '0;
         end else begin
            word_in = {solid_x[5:0], skip_x[9:0]};
            after.flush_valid = 1'b0;
         end
      end else begin
         kind_in = KIND_HEADER;
         rc_in = cur_ff.run_count;
         tc_in = cur_ff.texture_count;
         off_in = cur_ff.offset;
         after.hdr_valid = 1'b0;
      end
      last_in = !(after.tex_valid || after.flush_valid || after.hdr_valid);

      // The next command loads in the same cycle as the last word of this one.
      load = (!busy || (step && last_in)) && !fifo_empty;
      fifo_pop = load;
      if (load) begin
         cur_in = head;
      end else if (step) begin
         cur_in = after;
      end else begin
         cur_in = cur_ff;
      end

      if (step) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      rsp_valid = valid_ff;
      rsp_kind = kind_ff;
      rsp_word = word_ff;
      rsp_run_count = rc_ff;
      rsp_texture_count = tc_ff;
      rsp_column_offset = off_ff;
      rsp_last_of_run = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.tex_valid <= 1'b0;
         cur_ff.flush_valid <= 1'b0;
         cur_ff.hdr_valid <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         kind_ff <= kind_in;
         word_ff <= word_in;
         rc_ff <= rc_in;
         tc_ff <= tc_in;
         off_ff <= off_in;
         last_ff <= last_in;
      end
   end

endmodule

`default_nettype wire

@@ verif/tb_voxel_column_surface_rle_unit.sv @@
// Self-checking testbench for the voxel column surface run-length encoder.
// Depends on vcsr_pkg and voxel_column_surface_rle_unit; predicts every result word and
// checks it against the block while both queue interfaces idle at random.
`default_nettype none

module tb_voxel_column_surface_rle_unit
   import vcsr_pkg::*;
();

   // All 26 neighbour flags set: the voxel is buried and is never kept.
   localparam logic [NEIGHBOUR_W-1:0] ALL_SOLID = '1;
   // Room for late or extra words after the last expected one has arrived.
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS = 10;

   // Voxel classes used to build columns.
   localparam int VOXEL_KEPT = 0;
   localparam int VOXEL_BURIED = 1;
   localparam int VOXEL_EMPTY = 2;

   // One voxel waiting to be offered to the block.
   typedef struct {
      logic [15:0]            voxel;
      logic [NEIGHBOUR_W-1:0] neighbours;
      logic                   last;
   } voxel_item_type;

   // One result word as the block should present it.
   typedef struct {
      logic [1:0]       kind;
      logic [15:0]      word;
      logic [HDR_W-1:0] run_count;
      logic [HDR_W-1:0] texture_count;
      logic [31:0]      column_offset;
      logic             last_of_run;
   } column_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic [15:0]            req_voxel_word = '0;
   logic [NEIGHBOUR_W-1:0] req_neighbours_solid = '0;
   logic                   req_last_in_column = 1'b0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [1:0]             rsp_kind;
   logic [15:0]            rsp_word;
   logic [HDR_W-1:0]       rsp_run_count;
   logic [HDR_W-1:0]       rsp_texture_count;
   logic [31:0]            rsp_column_offset;
   logic                   rsp_last_of_run;

   voxel_column_surface_rle_unit uut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_voxel_word       (req_voxel_word),
      .req_neighbours_solid (req_neighbours_solid),
      .req_last_in_column   (req_last_in_column),
      .empty                (empty),
      .pop                  (pop),
      .rsp_kind             (rsp_kind),
      .rsp_word             (rsp_word),
      .rsp_run_count        (rsp_run_count),
      .rsp_texture_count    (rsp_texture_count),
      .rsp_column_offset    (rsp_column_offset),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   // The clock period is two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Voxels still to be offered, and result words the encoder model has predicted but the
   // block has not yet delivered, oldest first.
   voxel_item_type  pending_voxels[$];
   column_word_type expected_words[$];

   // Encoder model state: the open skip and solid runs, the words counted in the current
   // column and the record start offsets.
   logic [10:0]        skip_len = '0;
   logic [10:0]        solid_len = '0;
   logic [COUNT_W-1:0] col_runs = '0;
   logic [COUNT_W-1:0] col_textures = '0;
   logic [31:0]        col_start = '0;
   logic [31:0]        next_start = '0;

   int  mismatch_count = 0;
   bit  voxel_taken = 0;
   bit  word_taken = 0;
   int  voxel_gap = 0;
   int  word_gap = 0;
   // While calm is set, neither side idles, so back-to-back traffic is exercised as well.
   bit  calm = 0;

   task automatic push_expected(input logic [1:0] kind, input logic [15:0] word,
                                input logic [HDR_W-1:0] rc, input logic [HDR_W-1:0] tc,
                                input logic [31:0] off);
      column_word_type w;
      w.kind = kind;
      w.word = word;
      w.run_count = rc;
      w.texture_count = tc;
      w.column_offset = off;
      w.last_of_run = 1'b0;
      expected_words = {expected_words, w};
   endtask

   task automatic emit_run_word(input logic [15:0] word);
      push_expected(KIND_RUN, word, '0, '0, '0);
      if (col_runs < COUNT_MAX) col_runs++;
   endtask

   // Closing a run first spends any skip longer than one word can hold, then splits the
   // solid part into full words, of which only the first carries the skip.
   task automatic close_run();
      while (skip_len > SKIP_RUN_MAX) begin
         emit_run_word(16'(SKIP_RUN_MAX));
         skip_len -= 11'(SKIP_RUN_MAX);
      end
      while (solid_len > SOLID_RUN_MAX) begin
         emit_run_word({6'(SOLID_RUN_MAX), skip_len[9:0]});
         solid_len -= 11'(SOLID_RUN_MAX);
         skip_len = '0;
      end
      emit_run_word({solid_len[5:0], skip_len[9:0]});
      solid_len = '0;
      skip_len = '0;
   endtask

   // Predicts every word caused by one accepted voxel and marks the final one.
   task automatic encode_voxel(input logic [15:0] voxel, input logic [NEIGHBOUR_W-1:0] nb,
                               input logic last);
      int               first;
      logic             kept;
      logic [HDR_W-1:0] rc;
      logic [HDR_W-1:0] tc;
      first = expected_words.size();
      kept = voxel[15] && (nb != ALL_SOLID);
      if (kept) begin
         push_expected(KIND_TEXTURE, {1'b0, voxel[COLOUR_W-1:0]}, '0, '0, '0);
         if (col_textures < COUNT_MAX) col_textures++;
         if (solid_len < COLUMN_HEIGHT) solid_len++;
      end else begin
         if (solid_len > 0) close_run();
         if (skip_len < COLUMN_HEIGHT) skip_len++;
      end
      if (last) begin
         // The column end acts like an empty voxel above the top, so an open run closes.
         if (solid_len > 0) close_run();
         rc = (col_runs > HDR_MAX) ? HDR_W'(HDR_MAX) : col_runs[HDR_W-1:0];
         tc = (col_textures > HDR_MAX) ? HDR_W'(HDR_MAX) : col_textures[HDR_W-1:0];
         push_expected(KIND_HEADER, '0, rc, tc, col_start);
         // The offset advances by the internal counts, not the header ones, and wraps
         // at 32 bits.
         next_start = col_start + 32'd2 + 32'(col_runs) + 32'(col_textures);
         col_start = next_start;
         skip_len = '0;
         solid_len = '0;
         col_runs = '0;
         col_textures = '0;
      end
      if (expected_words.size() > first)
         expected_words[expected_words.size()-1].last_of_run = 1'b1;
   endtask

   // Idle lengths: mostly none or short, now and then a long stall.
   function automatic int next_idle();
      int r;
      if ($urandom_range(0, 63) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   // Random neighbour flags with at least one neighbour empty.
   function automatic logic [NEIGHBOUR_W-1:0] open_neighbours();
      logic [NEIGHBOUR_W-1:0] nb;
      nb = NEIGHBOUR_W'($urandom);
      if (nb == ALL_SOLID) nb[$urandom_range(0, NEIGHBOUR_W-1)] = 1'b0;
      return nb;
   endfunction

   task automatic add_voxel(input logic [15:0] voxel, input logic [NEIGHBOUR_W-1:0] nb,
                            input logic last);
      voxel_item_type v;
      v.voxel = voxel;
      v.neighbours = nb;
      v.last = last;
      pending_voxels = {pending_voxels, v};
   endtask

   // Voxel classes used to build columns: kept surface, buried solid and empty.
   task automatic add_class(input int cls, input logic last);
      logic [14:0] colour;
      colour = 15'($urandom);
      case (cls)
         VOXEL_KEPT: add_voxel({1'b1, colour}, open_neighbours(), last);
         VOXEL_BURIED: add_voxel({1'b1, colour}, ALL_SOLID, last);
         default: begin
            // Empty voxels carry random colour bits and, now and then, a full neighbourhood.
            if ($urandom_range(0, 3) == 0) add_voxel({1'b0, colour}, ALL_SOLID, last);
            else add_voxel({1'b0, colour}, NEIGHBOUR_W'($urandom), last);
         end
      endcase
   endtask

   // Random columns whose voxel classes tend to repeat, so runs of useful length form.
   task automatic add_random_columns(input int target);
      int count;
      int height;
      int cls;
      int r;
      count = 0;
      while (count < target) begin
         height = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 12);
         cls = $urandom_range(VOXEL_KEPT, VOXEL_EMPTY);
         for (int i = 0; i < height; i++) begin
            if ($urandom_range(0, 99) >= 65) begin
               r = $urandom_range(0, 99);
               cls = (r < 40) ? VOXEL_KEPT : (r < 60) ? VOXEL_BURIED : VOXEL_EMPTY;
            end
            add_class(cls, i == height - 1);
         end
         count += height;
      end
   endtask

   task automatic add_directed();
      // Single kept voxel at full colour with no solid neighbours forms a whole column.
      add_voxel(16'hFFFF, '0, 1'b1);
      // An empty voxel alone gives a header with no runs.
      add_voxel(16'h0000, '0, 1'b1);
      // A buried voxel alone behaves like an empty one.
      add_voxel(16'hFFFF, ALL_SOLID, 1'b1);
      // Mixed column: skips, kept voxels with one empty neighbour at either end of the
      // flags, a buried voxel splitting the run, and an empty top voxel.
      add_voxel(16'h7FFF, ALL_SOLID, 1'b0);
      add_voxel(16'h0000, ALL_SOLID, 1'b0);
      add_voxel(16'h8000, ALL_SOLID & ~NEIGHBOUR_W'(1), 1'b0);
      add_voxel(16'hFFFF, ALL_SOLID & ~(NEIGHBOUR_W'(1) << (NEIGHBOUR_W - 1)), 1'b0);
      add_voxel(16'hD555, ALL_SOLID, 1'b0);
      add_voxel(16'hAAAA, NEIGHBOUR_W'(1), 1'b0);
      add_voxel(16'h5555, '0, 1'b1);
      // A run that is still open at the column end is closed by the end itself.
      add_voxel(16'h0001, '0, 1'b0);
      add_voxel(16'h8001, '0, 1'b0);
      add_voxel(16'hFFFE, open_neighbours(), 1'b1);
      // Seventy kept voxels need two solid run words, the skip only on the first.
      add_voxel(16'h0000, '0, 1'b0);
      for (int i = 0; i < 70; i++) add_class(VOXEL_KEPT, i == 69);
   endtask

   // Sampling at the rising edge: the handshake and port values seen here are the ones that
   // were settled before the edge, so prediction and checking do not depend on event order.
   always @(posedge clock) begin
      voxel_taken = 0;
      word_taken = 0;
      if (!reset) begin
         if (push && !full) begin
            voxel_taken = 1;
            encode_voxel(req_voxel_word, req_neighbours_solid, req_last_in_column);
         end
         if (pop && !empty) begin
            word_taken = 1;
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected word: kind %0d word %h rc %0d tc %0d off %h last %0d",
                           rsp_kind, rsp_word, rsp_run_count, rsp_texture_count,
                           rsp_column_offset, rsp_last_of_run);
            end else begin
               if (rsp_kind !== expected_words[0].kind ||
                   rsp_word !== expected_words[0].word ||
                   rsp_run_count !== expected_words[0].run_count ||
                   rsp_texture_count !== expected_words[0].texture_count ||
                   rsp_column_offset !== expected_words[0].column_offset ||
                   rsp_last_of_run !== expected_words[0].last_of_run) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("mismatch expected: kind %0d word %h rc %0d tc %0d off %h last %0d",
                              expected_words[0].kind, expected_words[0].word,
                              expected_words[0].run_count, expected_words[0].texture_count,
                              expected_words[0].column_offset,
                              expected_words[0].last_of_run);
                     $display("         actual:   kind %0d word %h rc %0d tc %0d off %h last %0d",
                              rsp_kind, rsp_word, rsp_run_count, rsp_texture_count,
                              rsp_column_offset, rsp_last_of_run);
                  end
               end
               void'(expected_words.pop_front());
            end
         end
      end
   end

   // Voxel driver, updated at the falling edge. A voxel on offer stays on the ports until
   // the block takes it; after each accepted voxel a random gap may follow.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (voxel_taken) begin
            void'(pending_voxels.pop_front());
            voxel_gap = next_idle();
         end
         if (!(push && !voxel_taken)) begin
            if (voxel_gap > 0) begin
               push <= 1'b0;
               voxel_gap--;
            end else if (pending_voxels.size() != 0) begin
               push <= 1'b1;
               req_voxel_word <= pending_voxels[0].voxel;
               req_neighbours_solid <= pending_voxels[0].neighbours;
               req_last_in_column <= pending_voxels[0].last;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Result side: pop stays high except during random stalls chosen after each taken word.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (word_taken) word_gap = next_idle();
         if (word_gap > 0) begin
            pop <= 1'b0;
            word_gap--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Main sequence: build the whole stimulus, release reset, then wait for the block to
   // take every voxel and deliver every predicted word before the verdict.
   initial begin
      add_directed();
      add_random_columns(60);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_voxels.size() != 0) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      // Voxels that cause no word may still be in flight; extra words would show up here.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("tb_voxel_column_surface_rle_unit passed");
      end else begin
         $display("tb_voxel_column_surface_rle_unit failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake, set far beyond the slowest legal run.
   initial begin
      #20000000;
      $display("tb_voxel_column_surface_rle_unit failed");
      $finish;
   end

endmodule

`default_nettype wire
